/* rtl/btpc_pkg.sv */
package btpc_pkg;

	localparam int RAW_W      = 24;
	localparam int VAL_W      = 32;
	localparam int WORD_W     = 64;
	localparam int LIN_W      = 16;
	localparam int DIG_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;
	localparam int PC_W       = 6;
	localparam int SH_W       = 6;
	localparam int CHUNK_W    = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_TEMP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_A = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_B = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_C = 3'd3;

	localparam logic [WORD_W-1:0] K_25    = 64'd25;
	localparam logic [WORD_W-1:0] K_16384 = 64'd16384;

	// program entry and exit points in the microcode store
	localparam logic [PC_W-1:0] PC_PRESS     = 6'd0;
	localparam logic [PC_W-1:0] PC_PRESS_END = 6'd32;
	localparam logic [PC_W-1:0] PC_TEMP      = 6'd40;
	localparam logic [PC_W-1:0] PC_TEMP_END  = 6'd48;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} st_t;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_ASR,
		OP_LSR,
		OP_MUL,
		OP_SETLIN
	} op_t;

	typedef enum logic [2:0] {
		D_R0,
		D_R1,
		D_R2,
		D_R3,
		D_R4,
		D_R5
	} dst_t;

	typedef enum logic [4:0] {
		S_R0, S_R1, S_R2, S_R3, S_R4, S_R5,
		S_RAW, S_TL,
		S_T1, S_T2, S_T3,
		S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9, S_P10, S_P11,
		S_K25, S_K16384, S_ZERO
	} src_t;

	localparam int SRC_NUM = 25;

	typedef struct packed {
		op_t                op;
		dst_t               dst;
		src_t               src_a;
		src_t               src_b;
		logic [SH_W-1:0]    sh;
		logic [CHUNK_W-1:0] nlast;
		logic               last;
	} uinst_t;

	function automatic uinst_t ui(input op_t op, input dst_t dst, input src_t a, input src_t b,
		input logic [SH_W-1:0] sh, input logic [CHUNK_W-1:0] nlast, input logic last);
		uinst_t u;
		u.op    = op;
		u.dst   = dst;
		u.src_a = a;
		u.src_b = b;
		u.sh    = sh;
		u.nlast = nlast;
		u.last  = last;
		return u;
	endfunction

	// mul: dst = a * b, b taken 16 bits per cycle, nlast+1 chunks, top chunk signed
	// add/sub: dst = a +/- (b << sh)
	function automatic uinst_t ucode(input logic [PC_W-1:0] pc);
		uinst_t u;
		unique case (pc)
			// pressure
			6'd0:  u = ui(OP_MUL, D_R0, S_TL,  S_TL,     6'd0,  2'd0, 1'b0);
			6'd1:  u = ui(OP_MUL, D_R1, S_R0,  S_TL,     6'd0,  2'd0, 1'b0);
			6'd2:  u = ui(OP_MUL, D_R2, S_R1,  S_P8,     6'd0,  2'd0, 1'b0);
			6'd3:  u = ui(OP_ADD, D_R2, S_R2,  S_P5,     6'd18, 2'd0, 1'b0);
			6'd4:  u = ui(OP_MUL, D_R3, S_R0,  S_P7,     6'd0,  2'd0, 1'b0);
			6'd5:  u = ui(OP_ADD, D_R2, S_R2,  S_R3,     6'd7,  2'd0, 1'b0);
			6'd6:  u = ui(OP_MUL, D_R3, S_P6,  S_TL,     6'd0,  2'd0, 1'b0);
			6'd7:  u = ui(OP_ADD, D_R2, S_R2,  S_R3,     6'd9,  2'd0, 1'b0);
			6'd8:  u = ui(OP_MUL, D_R3, S_R1,  S_P4,     6'd0,  2'd0, 1'b0);
			6'd9:  u = ui(OP_SUB, D_R4, S_P1,  S_K16384, 6'd0,  2'd0, 1'b0);
			6'd10: u = ui(OP_ADD, D_R3, S_R3,  S_R4,     6'd17, 2'd0, 1'b0);
			6'd11: u = ui(OP_MUL, D_R4, S_R0,  S_P3,     6'd0,  2'd0, 1'b0);
			6'd12: u = ui(OP_ADD, D_R3, S_R3,  S_R4,     6'd5,  2'd0, 1'b0);
			6'd13: u = ui(OP_SUB, D_R4, S_P2,  S_K16384, 6'd0,  2'd0, 1'b0);
			6'd14: u = ui(OP_MUL, D_R4, S_R4,  S_TL,     6'd0,  2'd0, 1'b0);
			6'd15: u = ui(OP_ADD, D_R3, S_R3,  S_R4,     6'd8,  2'd0, 1'b0);
			6'd16: u = ui(OP_MUL, D_R3, S_R3,  S_RAW,    6'd0,  2'd1, 1'b0);
			6'd17: u = ui(OP_MUL, D_R4, S_P10, S_TL,     6'd0,  2'd0, 1'b0);
			6'd18: u = ui(OP_ADD, D_R4, S_R4,  S_P9,     6'd0,  2'd0, 1'b0);
			6'd19: u = ui(OP_MUL, D_R4, S_R4,  S_RAW,    6'd0,  2'd1, 1'b0);
			6'd20: u = ui(OP_MUL, D_R4, S_R4,  S_RAW,    6'd0,  2'd1, 1'b0);
			6'd21: u = ui(OP_MUL, D_R5, S_RAW, S_RAW,    6'd0,  2'd1, 1'b0);
			6'd22: u = ui(OP_ASR, D_R5, S_R5,  S_ZERO,   6'd9,  2'd0, 1'b0);
			6'd23: u = ui(OP_MUL, D_R5, S_R5,  S_RAW,    6'd0,  2'd1, 1'b0);
			6'd24: u = ui(OP_ASR, D_R5, S_R5,  S_ZERO,   6'd8,  2'd0, 1'b0);
			6'd25: u = ui(OP_MUL, D_R5, S_R5,  S_P11,    6'd0,  2'd0, 1'b0);
			6'd26: u = ui(OP_ADD, D_R4, S_R4,  S_R5,     6'd0,  2'd0, 1'b0);
			6'd27: u = ui(OP_ASR, D_R4, S_R4,  S_ZERO,   6'd11, 2'd0, 1'b0);
			6'd28: u = ui(OP_ADD, D_R4, S_R4,  S_R3,     6'd0,  2'd0, 1'b0);
			6'd29: u = ui(OP_ASR, D_R4, S_R4,  S_ZERO,   6'd22, 2'd0, 1'b0);
			6'd30: u = ui(OP_ADD, D_R4, S_R4,  S_R2,     6'd0,  2'd0, 1'b0);
			6'd31: u = ui(OP_MUL, D_R4, S_R4,  S_K25,    6'd0,  2'd0, 1'b0);
			6'd32: u = ui(OP_LSR, D_R4, S_R4,  S_ZERO,   6'd13, 2'd0, 1'b1);
			// temperature
			6'd40: u = ui(OP_SUB, D_R0, S_RAW, S_T1,     6'd8,  2'd0, 1'b0);
			6'd41: u = ui(OP_MUL, D_R1, S_T2,  S_R0,     6'd0,  2'd1, 1'b0);
			6'd42: u = ui(OP_MUL, D_R2, S_R0,  S_R0,     6'd0,  2'd1, 1'b0);
			6'd43: u = ui(OP_MUL, D_R2, S_R2,  S_T3,     6'd0,  2'd0, 1'b0);
			6'd44: u = ui(OP_ADD, D_R1, S_R2,  S_R1,     6'd18, 2'd0, 1'b0);
			6'd45: u = ui(OP_ASR, D_R1, S_R1,  S_ZERO,   6'd32, 2'd0, 1'b0);
			6'd46: u = ui(OP_SETLIN, D_R1, S_R1, S_ZERO, 6'd0,  2'd0, 1'b0);
			6'd47: u = ui(OP_MUL, D_R1, S_R1,  S_K25,    6'd0,  2'd0, 1'b0);
			6'd48: u = ui(OP_ASR, D_R1, S_R1,  S_ZERO,   6'd14, 2'd0, 1'b1);
			default: u = ui(OP_ADD, D_R0, S_ZERO, S_ZERO, 6'd0, 2'd0, 1'b1);
		endcase
		return u;
	endfunction

endpackage

/* rtl/btpc_if.sv */
interface btpc_sample_if;
	logic                          valid;
	logic                          ready;
	logic                          opcode;
	logic [btpc_pkg::RAW_W-1:0]    raw_sample;

	modport source (output valid, output opcode, output raw_sample, input ready);
	modport sink (input valid, input opcode, input raw_sample, output ready);
endinterface

interface btpc_result_if;
	logic                               valid;
	logic                               ready;
	logic                               kind;
	logic signed [btpc_pkg::VAL_W-1:0]  comp_value;

	modport source (output valid, output kind, output comp_value, input ready);
	modport sink (input valid, input kind, input comp_value, output ready);
endinterface

interface btpc_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [btpc_pkg::CFG_IDX_W-1:0]    index;
	logic [btpc_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/baro_temp_pressure_compensation.sv */
// barometric compensation core
// sample channel: an item carries opcode (0 temperature, 1 pressure) and a 24-bit raw
// reading. result channel: one item per sample, kind echoes opcode, comp_value is the
// compensated value in hundredths, wrapped to signed 32 bits.
// cfg channel: index 0..3 writes temp_coeffs, press_coeffs_a/b/c; other indexes are
// dropped. cfg is always ready and is meant to be written while no item is in flight.
// a temperature item also updates the stored linearized temperature that later pressure
// items use (zero after reset).
// all arithmetic runs through one 64-bit by 16-bit multiply-accumulate/shift unit
// stepped by a microcode sequencer, one 16-bit multiplier chunk per cycle.
// one item at a time: sample.ready is high only while the sequencer is idle. the result
// sits in an output register, so the next item can be taken while it waits; if it is
// still untaken when the next item finishes, the sequencer holds on its last step until
// result.ready.
// reset clears coefficients, stored temperature and all handshake state.
module baro_temp_pressure_compensation (
	input  logic                 clk,
	input  logic                 arst_n,
	btpc_sample_if.sink          sample,
	btpc_result_if.source        result,
	btpc_cfg_if.sink             cfg
);
	import btpc_pkg::*;

	st_t                      state_q, state_d;
	logic [PC_W-1:0]          pc_q;
	logic [CHUNK_W-1:0]       chunk_q;
	logic                     out_valid_q;
	logic [LIN_W-1:0]         lin_q;
	logic [39:0]              tco_q;
	logic [47:0]              pca_q;
	logic [47:0]              pcb_q;
	logic [31:0]              pcc_q;

	logic [RAW_W-1:0]         raw_q;
	logic [WORD_W-1:0]        r0_q, r1_q, r2_q, r3_q, r4_q, r5_q;
	logic [WORD_W-1:0]        acc_q;
	logic                     kind_q;
	logic [VAL_W-1:0]         comp_q;
	logic                     op_q;

	uinst_t                   u;
	logic [WORD_W-1:0]        src_vec [SRC_NUM];
	logic [WORD_W-1:0]        opa, opb, bsh, alu_res;
	logic [DIG_W-1:0]         digit;
	logic [DIG_W:0]           dig17;
	logic [WORD_W-1:0]        prod, pp, mul_sum;
	logic                     accept, step_done, out_busy, commit, mul_step, finish, cfg_wr;

	assign u = ucode(pc_q);

	always_comb begin
		src_vec[S_R0]     = r0_q;
		src_vec[S_R1]     = r1_q;
		src_vec[S_R2]     = r2_q;
		src_vec[S_R3]     = r3_q;
		src_vec[S_R4]     = r4_q;
		src_vec[S_R5]     = r5_q;
		src_vec[S_RAW]    = {{(WORD_W-RAW_W){1'b0}}, raw_q};
		src_vec[S_TL]     = {{(WORD_W-LIN_W){lin_q[LIN_W-1]}}, lin_q};
		src_vec[S_T1]     = {48'd0, tco_q[15:0]};
		src_vec[S_T2]     = {48'd0, tco_q[31:16]};
		src_vec[S_T3]     = {{56{tco_q[39]}}, tco_q[39:32]};
		src_vec[S_P1]     = {{48{pca_q[15]}}, pca_q[15:0]};
		src_vec[S_P2]     = {{48{pca_q[31]}}, pca_q[31:16]};
		src_vec[S_P3]     = {{56{pca_q[39]}}, pca_q[39:32]};
		src_vec[S_P4]     = {{56{pca_q[47]}}, pca_q[47:40]};
		src_vec[S_P5]     = {48'd0, pcb_q[15:0]};
		src_vec[S_P6]     = {48'd0, pcb_q[31:16]};
		src_vec[S_P7]     = {{56{pcb_q[39]}}, pcb_q[39:32]};
		src_vec[S_P8]     = {{56{pcb_q[47]}}, pcb_q[47:40]};
		src_vec[S_P9]     = {{48{pcc_q[15]}}, pcc_q[15:0]};
		src_vec[S_P10]    = {{56{pcc_q[23]}}, pcc_q[23:16]};
		src_vec[S_P11]    = {{56{pcc_q[31]}}, pcc_q[31:24]};
		src_vec[S_K25]    = K_25;
		src_vec[S_K16384] = K_16384;
		src_vec[S_ZERO]   = '0;
	end

	assign opa = src_vec[u.src_a];
	assign opb = src_vec[u.src_b];
	assign bsh = opb << u.sh;

	// one 16-bit chunk of b per cycle; the top chunk carries the sign
	assign digit   = opb[{chunk_q, 4'b0000} +: DIG_W];
	assign dig17   = (chunk_q == u.nlast) ? {digit[DIG_W-1], digit} : {1'b0, digit};
	assign prod    = opa * {{(WORD_W-DIG_W-1){dig17[DIG_W]}}, dig17};
	assign pp      = prod << {chunk_q, 4'b0000};
	assign mul_sum = ((chunk_q == '0) ? '0 : acc_q) + pp;

	always_comb begin
		unique case (u.op)
			OP_ADD:    alu_res = opa + bsh;
			OP_SUB:    alu_res = opa - bsh;
			OP_ASR:    alu_res = $unsigned($signed(opa) >>> u.sh);
			OP_LSR:    alu_res = opa >> u.sh;
			OP_MUL:    alu_res = mul_sum;
			OP_SETLIN: alu_res = opa;
			default:   alu_res = opa;
		endcase
	end

	assign accept    = sample.valid && sample.ready;
	assign cfg_wr    = cfg.valid && cfg.ready;
	assign step_done = (u.op != OP_MUL) || (chunk_q == u.nlast);
	assign out_busy  = out_valid_q && !result.ready;
	assign commit    = (state_q == ST_RUN) && step_done && !(u.last && out_busy);
	assign mul_step  = (state_q == ST_RUN) && !step_done;
	assign finish    = commit && u.last;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (finish) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		sample.ready      = (state_q == ST_IDLE);
		cfg.ready         = 1'b1;
		result.valid      = out_valid_q;
		result.kind       = kind_q;
		result.comp_value = comp_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pc_q        <= '0;
			chunk_q     <= '0;
			out_valid_q <= 1'b0;
			lin_q       <= '0;
			tco_q       <= '0;
			pca_q       <= '0;
			pcb_q       <= '0;
			pcc_q       <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				pc_q    <= sample.opcode ? PC_PRESS : PC_TEMP;
				chunk_q <= '0;
			end else if (commit) begin
				pc_q    <= pc_q + 1'b1;
				chunk_q <= '0;
			end else if (mul_step) begin
				chunk_q <= chunk_q + 1'b1;
			end
			if (finish) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
			if (commit && u.op == OP_SETLIN) lin_q <= opa[31:16];
			if (cfg_wr) begin
				unique case (cfg.index)
					CFG_TEMP:    tco_q <= cfg.data[39:0];
					CFG_PRESS_A: pca_q <= cfg.data;
					CFG_PRESS_B: pcb_q <= cfg.data;
					CFG_PRESS_C: pcc_q <= cfg.data[31:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			raw_q <= sample.raw_sample;
			op_q  <= sample.opcode;
		end
		if (mul_step) acc_q <= mul_sum;
		if (commit && u.op != OP_SETLIN) begin
			unique case (u.dst)
				D_R0:    r0_q <= alu_res;
				D_R1:    r1_q <= alu_res;
				D_R2:    r2_q <= alu_res;
				D_R3:    r3_q <= alu_res;
				D_R4:    r4_q <= alu_res;
				D_R5:    r5_q <= alu_res;
				default: ;
			endcase
		end
		if (finish) begin
			kind_q <= op_q;
			comp_q <= alu_res[VAL_W-1:0];
		end
	end

	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_RUN)
		else $error("accepted item did not start the sequencer");

	a_chunk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> chunk_q <= u.nlast)
		else $error("multiplier chunk count ran past the operand");

	a_pc_in_program: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> (pc_q <= PC_PRESS_END
			|| (pc_q >= PC_TEMP && pc_q <= PC_TEMP_END)))
		else $error("sequencer left its program");

	a_result_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_RUN))
		else $error("result raised without a finished item");

endmodule
